/* hw/rtl/rpdc_pkg.sv */
// Package for the record/playback drift control block.
// Holds widths, fixed-point constants, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rpdc_pkg;

    localparam int POS_BITS   = 18;
    localparam int TOTAL_BITS = 40;
    localparam int REC_BITS   = 32;
    localparam int THR_BITS   = 17;
    localparam int CFG_BITS   = 18;

    // Q0.16 decay 0.97 and its complement
    localparam logic [18:0] DECAY_Q16   = 19'd63570;
    localparam logic [18:0] GAIN_Q16    = 19'd1966;
    // floor(x / 50) = (x * DIV50_RECIP) >> 24 for any 18-bit x
    localparam logic [18:0] DIV50_RECIP = 19'd335545;

    localparam logic [CFG_BITS-1:0] BUFFER_LENGTH_RST   = 18'd240000;
    localparam logic [CFG_BITS-1:0] SAMPLE_RATE_RST     = 18'd48000;
    localparam logic [CFG_BITS-1:0] START_LATENCY_RST   = 18'd2400;
    localparam logic [THR_BITS-1:0] DRIFT_THRESHOLD_RST = 17'd1200;

    typedef enum logic [1:0] {
        CFG_BUFFER_LENGTH   = 2'd0,
        CFG_SAMPLE_RATE     = 2'd1,
        CFG_START_LATENCY   = 2'd2,
        CFG_DRIFT_THRESHOLD = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC_LO,
        ST_DEC_HI,
        ST_DEC_SUM,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_GAIN_SUM,
        ST_RATE,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/record_playback_drift_control.sv */
// The rate is recomputed (states ST_DEC_LO..ST_RATE) while playback runs or starts and the
// record position moves. New items are taken only in ST_IDLE, once the output is loaded;
// the single shared 20x19 multiplier is used five times per recomputed update.
// Reset (aresetn, synchronous, active low): config registers to defaults, latency target
// from start_latency, smoothing total and counters cleared, no item pending.
// Depends on rpdc_pkg.
`timescale 1ns / 1ps

module record_playback_drift_control
    import rpdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // record_pos, play_pos, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // playback_rate, smoothed_distance, latency_target,
                                   // record_advance
    output logic [1:0]  m_tuser    // playback_started, rate_valid
);

    state_t state_reg, state_next;

    logic [POS_BITS-1:0]   buffer_length_reg, sample_rate_reg;
    logic [THR_BITS-1:0]   drift_threshold_reg;

    logic [POS_BITS-1:0]   last_pos_reg, min_adv_reg, goal_reg;
    logic [REC_BITS-1:0]   rec_total_reg;
    logic                  playing_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [POS_BITS-1:0]   smooth_reg, adv_reg, dist_reg, rate_reg;
    logic                  started_reg, valid_reg;
    logic [38:0]           prod_reg, lo_reg;

    logic                  m_valid_reg;
    logic [71:0]           m_data_reg;
    logic [1:0]            m_user_reg;

    // input side
    logic                  accept;
    logic [POS_BITS-1:0]   rp, pp, adv, play_gap;
    logic [REC_BITS:0]     rec_sum;
    logic [REC_BITS-1:0]   rec_sat;
    logic                  start, track;

    // shared multiplier
    logic [19:0]           mul_a;
    logic [18:0]           mul_b;
    logic [38:0]           mul_p;

    logic [58:0]           wide;
    logic [TOTAL_BITS:0]   dsum;
    logic [26:0]           gval;
    logic [POS_BITS-1:0]   step, rate_slow, rate_fast;
    logic [POS_BITS:0]     fast_sum, hi_band;
    logic signed [POS_BITS:0] lo_band;
    logic                  slow_cond, fast_cond, out_load;

    assign accept = s_tvalid && s_tready;
    assign rp     = s_tdata[POS_BITS-1:0];
    assign pp     = s_tdata[2*POS_BITS-1:POS_BITS];

    assign adv      = rp - last_pos_reg + ((rp < last_pos_reg) ? buffer_length_reg : '0);
    assign play_gap = rp - pp + ((rp < pp) ? buffer_length_reg : '0);

    assign rec_sum = {1'b0, rec_total_reg} + {{(REC_BITS+1-POS_BITS){1'b0}}, adv};
    assign rec_sat = rec_sum[REC_BITS] ? '1 : rec_sum[REC_BITS-1:0];
    assign start   = !playing_reg && (rec_sat >= {{(REC_BITS-POS_BITS){1'b0}}, goal_reg});
    assign track   = (playing_reg || start) && (adv != '0);

    assign mul_p = {19'b0, mul_a} * {20'b0, mul_b};

    assign wide = {prod_reg, 20'b0} + {20'b0, lo_reg};
    assign dsum = {1'b0, wide[55:16]} + {7'b0, dist_reg, 16'b0};
    assign gval = wide[58:32];

    assign step      = {3'b0, prod_reg[38:24]};
    assign rate_slow = sample_rate_reg - step;
    assign fast_sum  = {1'b0, sample_rate_reg} + {1'b0, step};
    assign rate_fast = fast_sum[POS_BITS] ? '1 : fast_sum[POS_BITS-1:0];
    assign lo_band   = $signed({1'b0, goal_reg}) - $signed({2'b0, drift_threshold_reg});
    assign hi_band   = {1'b0, goal_reg} + {2'b0, drift_threshold_reg};
    assign slow_cond = ($signed({1'b0, smooth_reg}) < lo_band)
                    || (smooth_reg > (buffer_length_reg >> 1));
    assign fast_cond = {1'b0, smooth_reg} > hi_band;

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = track ? ST_DEC_LO : ST_DONE;
            ST_DEC_LO:   state_next = ST_DEC_HI;
            ST_DEC_HI:   state_next = ST_DEC_SUM;
            ST_DEC_SUM:  state_next = ST_GAIN_LO;
            ST_GAIN_LO:  state_next = ST_GAIN_HI;
            ST_GAIN_HI:  state_next = ST_GAIN_SUM;
            ST_GAIN_SUM: state_next = ST_RATE;
            ST_RATE:     state_next = ST_DONE;
            ST_DONE:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE:     s_tready = 1'b1;
            ST_DEC_LO: begin
                mul_a = total_reg[19:0];
                mul_b = DECAY_Q16;
            end
            ST_DEC_HI: begin
                mul_a = total_reg[39:20];
                mul_b = DECAY_Q16;
            end
            ST_GAIN_LO: begin
                mul_a = total_reg[19:0];
                mul_b = GAIN_Q16;
            end
            ST_GAIN_HI: begin
                mul_a = total_reg[39:20];
                mul_b = GAIN_Q16;
            end
            ST_GAIN_SUM: begin
                mul_a = {2'b0, sample_rate_reg};
                mul_b = DIV50_RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            buffer_length_reg   <= BUFFER_LENGTH_RST;
            sample_rate_reg     <= SAMPLE_RATE_RST;
            drift_threshold_reg <= DRIFT_THRESHOLD_RST;
            last_pos_reg        <= '0;
            rec_total_reg       <= '0;
            playing_reg         <= 1'b0;
            min_adv_reg         <= '1;
            goal_reg            <= START_LATENCY_RST;
            total_reg           <= '0;
            smooth_reg          <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BUFFER_LENGTH: buffer_length_reg <= cfg_wdata;
                    CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_wdata;
                    CFG_START_LATENCY: begin
                        if (!playing_reg) goal_reg <= cfg_wdata;
                    end
                    CFG_DRIFT_THRESHOLD: drift_threshold_reg <= cfg_wdata[THR_BITS-1:0];
                    default: ;
                endcase
            end

            prod_reg <= mul_p;

            case (state_reg)
                ST_IDLE: if (accept) begin
                    last_pos_reg  <= rp;
                    rec_total_reg <= rec_sat;
                    if (start) playing_reg <= 1'b1;
                    started_reg   <= start;
                    valid_reg     <= track;
                    rate_reg      <= '0;
                    adv_reg       <= adv;
                    dist_reg      <= play_gap;
                    if (track && (adv < min_adv_reg)) begin
                        min_adv_reg <= adv;
                        if (goal_reg < adv) goal_reg <= adv;
                    end
                end
                ST_DEC_HI:  lo_reg <= prod_reg;
                ST_DEC_SUM: total_reg <= dsum[TOTAL_BITS] ? '1 : dsum[TOTAL_BITS-1:0];
                ST_GAIN_HI: lo_reg <= prod_reg;
                ST_GAIN_SUM: smooth_reg <= (|gval[26:POS_BITS]) ? '1 : gval[POS_BITS-1:0];
                ST_RATE: begin
                    if (slow_cond)      rate_reg <= rate_slow;
                    else if (fast_cond) rate_reg <= rate_fast;
                    else                rate_reg <= sample_rate_reg;
                end
                default: ;
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {adv_reg, goal_reg, smooth_reg, rate_reg};
                m_user_reg  <= {valid_reg, started_reg};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a recomputed rate only comes out once playback runs
    a_valid_needs_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> playing_reg)
        else $error("rate_valid without playback");

    a_rate_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[17:0] == '0)
        else $error("nonzero rate on a non-recomputed item");

    a_goal_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg && $past(playing_reg) |-> goal_reg >= $past(goal_reg))
        else $error("latency target dropped during playback");

    a_min_tracked_only_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        min_adv_reg != '1 |-> playing_reg)
        else $error("minimum advance tracked before playback");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while an update is in work");

endmodule
